### rtl/irbe_pkg.sv
// Package for the IR ring bearing estimator: field widths, CORDIC constants and
// the elaboration-time function that builds the Q1.15 sensor coefficients.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irbe_pkg;
	localparam int SAMPLE_W = 10;
	localparam int BEARING_W = 9;
	localparam int MEAN_W = 11;
	localparam int PATCH_W = 5;
	localparam int PATCH_RESET = 22;
	localparam int COEF_W = 17;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = 5;
	localparam int ANGLE_W = 28;
	localparam longint DEG_UNIT = 65536;
	localparam longint GAIN_Q30 = 652032874;

	typedef struct packed {
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] s;
	} cs_t;

	function automatic longint atan_q16(input int k);
		longint v;
		case (k)
			0: v = 2949120;
			1: v = 1740967;
			2: v = 919879;
			3: v = 466945;
			4: v = 234379;
			5: v = 117304;
			6: v = 58666;
			7: v = 29335;
			8: v = 14668;
			9: v = 7334;
			10: v = 3667;
			11: v = 1833;
			12: v = 917;
			13: v = 458;
			14: v = 229;
			15: v = 115;
			16: v = 57;
			17: v = 29;
			18: v = 14;
			19: v = 7;
			20: v = 4;
			21: v = 2;
			22: v = 1;
			default: v = 0;
		endcase
		return v;
	endfunction

	// Rotation CORDIC on an angle in 1/65536 degree, rounded half up to Q15.
	function automatic cs_t unit_cs(input longint angle);
		longint t;
		longint x;
		longint y;
		longint nx;
		longint ny;
		cs_t r;
		t = angle;
		x = GAIN_Q30;
		y = 0;
		if (t > 180 * DEG_UNIT) t = t - 360 * DEG_UNIT;
		if (t > 90 * DEG_UNIT) begin
			x = 0; y = GAIN_Q30; t = t - 90 * DEG_UNIT;
		end else if (t < -90 * DEG_UNIT) begin
			x = 0; y = -GAIN_Q30; t = t + 90 * DEG_UNIT;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (t >= 0) begin
				nx = x - (y >>> k); ny = y + (x >>> k); t = t - atan_q16(k);
			end else begin
				nx = x + (y >>> k); ny = y - (x >>> k); t = t + atan_q16(k);
			end
			x = nx; y = ny;
		end
		r.c = COEF_W'((x + 16384) >>> 15);
		r.s = COEF_W'((y + 16384) >>> 15);
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/irbe_in_if.sv
// Input channel: one raw ADC sample per beat.
// Depends on irbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface irbe_in_if import irbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] raw_sample;
	modport source (output valid, output raw_sample, input ready);
	modport sink (input valid, input raw_sample, output ready);
endinterface
`default_nettype wire

### rtl/irbe_out_if.sv
// Output channel: bearing and mean level, one beat per completed ring.
// Depends on irbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface irbe_out_if import irbe_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [BEARING_W-1:0] bearing_deg;
	logic [MEAN_W-1:0] mean_level;
	modport source (output valid, output bearing_deg, output mean_level, input ready);
	modport sink (input valid, input bearing_deg, input mean_level, output ready);
endinterface
`default_nettype wire

### rtl/irbe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module irbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/irbe_atan.sv
// Iterative vectoring CORDIC giving the bearing of (bx, by) in whole degrees,
// one micro-rotation per cycle, with the exact special cases. Depends on irbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module irbe_atan import irbe_pkg::*; #(
	parameter int XW = 33
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [XW-1:0] bx,
	input wire logic signed [XW-1:0] by,
	output logic done,
	output logic signed [BEARING_W-1:0] deg
);
	localparam int CW = XW + 18;

	logic run_q;
	logic [STEP_W-1:0] k_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [ANGLE_W-1:0] z_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [XW:0] ax;
	logic signed [XW:0] ay;
	logic signed [ANGLE_W-1:0] step_a;
	logic signed [ANGLE_W-1:0] zt;

	assign xs = CW'(bx) <<< 16;
	assign ys = CW'(by) <<< 16;
	assign ax = bx[XW-1] ? -(XW+1)'(bx) : (XW+1)'(bx);
	assign ay = by[XW-1] ? -(XW+1)'(by) : (XW+1)'(by);
	assign step_a = ANGLE_W'(atan_q16(int'(k_q)));
	assign zt = z_q[ANGLE_W-1] ? -((-z_q) >>> 16) : (z_q >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			k_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				k_q <= '0;
				if (by == 0) begin
					deg <= bx[XW-1] ? BEARING_W'(180) : BEARING_W'(0);
					done <= 1'b1;
				end else if (bx == 0) begin
					deg <= by[XW-1] ? -BEARING_W'(90) : BEARING_W'(90);
					done <= 1'b1;
				end else if (ax == ay) begin
					if (bx[XW-1]) deg <= by[XW-1] ? -BEARING_W'(135) : BEARING_W'(135);
					else deg <= by[XW-1] ? -BEARING_W'(45) : BEARING_W'(45);
					done <= 1'b1;
				end else begin
					run_q <= 1'b1;
					if (bx[XW-1]) begin
						if (!by[XW-1]) begin
							x_q <= ys; y_q <= -xs; z_q <= ANGLE_W'(90 * DEG_UNIT);
						end else begin
							x_q <= -ys; y_q <= xs; z_q <= -ANGLE_W'(90 * DEG_UNIT);
						end
					end else begin
						x_q <= xs; y_q <= ys; z_q <= '0;
					end
				end
			end else if (run_q) begin
				if (k_q == STEP_W'(CORDIC_STEPS)) begin
					run_q <= 1'b0;
					done <= 1'b1;
					if (zt > ANGLE_W'(180)) deg <= BEARING_W'(180);
					else if (zt < -ANGLE_W'(180)) deg <= -BEARING_W'(180);
					else deg <= BEARING_W'(zt);
				end else begin
					k_q <= k_q + 1'b1;
					if (y_q > 0) begin
						x_q <= x_q + (y_q >>> k_q);
						y_q <= y_q - (x_q >>> k_q);
						z_q <= z_q + step_a;
					end else begin
						x_q <= x_q - (y_q >>> k_q);
						y_q <= y_q + (x_q >>> k_q);
						z_q <= z_q - step_a;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !start) else $error("atan started while busy");
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !start && k_q == STEP_W'(CORDIC_STEPS)) |=> (done && !run_q))
		else $error("atan run did not finish");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= STEP_W'(CORDIC_STEPS)) else $error("atan step count overran");
`endif
endmodule
`default_nettype wire

### rtl/ir_ring_bearing_estimator_core.sv
// Top level of the IR ring bearing estimator: sample store, frame-end sequencer with
// a shared multiplier for the weighted sum, and the CORDIC bearing unit.
// Depends on irbe_pkg, irbe_in_if, irbe_out_if, irbe_ram and irbe_atan.
//
// Channel    Dir  Payload                        Beat
// in_ch      in   raw_sample[9:0]                one sensor sample, ring order
// out_ch     out  bearing_deg[8:0], mean_level   one per completed ring
// cfg_we     in   cfg_wdata[4:0] patched_sensor  write on cfg_we high
//
// A sample that does not end a ring is stored as it is accepted. The last sample of a
// ring starts the frame pass: repair reads and checks each sensor and rebuilds a failed
// one from its two neighbours, through the single read port of the store; the patch
// rebuilds the configured sensor if in range; the weighted sum scales each sensor by
// cosine and sine on the shared multiplier; then the CORDIC, shorter for exact cases.
// in_ch.ready is low during the pass and while the finished result waits for the output.
// Reset clears control state only; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module ir_ring_bearing_estimator_core import irbe_pkg::*; #(
	parameter int SENSOR_COUNT = 24,
	parameter int SAMPLE_FULL_SCALE = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [PATCH_W-1:0] cfg_wdata,
	irbe_in_if.sink in_ch,
	irbe_out_if.source out_ch
);
	localparam int IW = $clog2(SENSOR_COUNT);
	localparam int RW = $clog2(SAMPLE_FULL_SCALE + 1);
	localparam int SW = RW + IW;
	localparam int PW = RW + 1 + COEF_W;
	localparam int XW = PW + IW + 1;
	localparam int DIV_K = SW + IW;
	localparam longint DIV_M = ((longint'(1) << DIV_K) + SENSOR_COUNT - 1) / SENSOR_COUNT;
	localparam int MPW = SW + DIV_K + 1;

	localparam logic [3:0] S_IN = 4'd0;
	localparam logic [3:0] S_RP_RD = 4'd1;
	localparam logic [3:0] S_RP_CHK = 4'd2;
	localparam logic [3:0] S_NB_A = 4'd3;
	localparam logic [3:0] S_NB_B = 4'd4;
	localparam logic [3:0] S_PT = 4'd5;
	localparam logic [3:0] S_PT_RD = 4'd6;
	localparam logic [3:0] S_SM_RD = 4'd7;
	localparam logic [3:0] S_SM_C = 4'd8;
	localparam logic [3:0] S_SM_S = 4'd9;
	localparam logic [3:0] S_SM_A = 4'd10;
	localparam logic [3:0] S_START = 4'd11;
	localparam logic [3:0] S_WAIT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic signed [COEF_W-1:0] cos_tab [SENSOR_COUNT];
	logic signed [COEF_W-1:0] sin_tab [SENSOR_COUNT];

	for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_coef
		localparam longint ANG = (longint'(g + 1) * 360 * DEG_UNIT) / SENSOR_COUNT;
		localparam cs_t CS = unit_cs(ANG);
		assign cos_tab[g] = CS.c;
		assign sin_tab[g] = CS.s;
	end

	logic [3:0] state_q;
	logic [PATCH_W-1:0] patched_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cnt_q;
	logic patch_phase_q;
	logic [RW-1:0] a_q;
	logic [RW-1:0] rd_q;
	logic signed [PW-1:0] prod_q;
	logic signed [XW-1:0] sx_q;
	logic signed [XW-1:0] sy_q;
	logic [SW-1:0] msum_q;
	logic bdone_q;
	logic out_valid_q;
	logic signed [BEARING_W-1:0] bearing_q;
	logic [MEAN_W-1:0] mean_q;

	logic we;
	logic [IW-1:0] waddr;
	logic [RW-1:0] wdata;
	logic [IW-1:0] raddr;
	logic [RW-1:0] rdata;
	logic [IW-1:0] up_idx;
	logic [IW-1:0] dn_idx;
	logic [RW-1:0] reading;
	logic [RW-1:0] nb_mean;
	logic failed;
	logic last;
	logic accept;
	logic out_free;
	logic atan_start;
	logic atan_done;
	logic signed [BEARING_W-1:0] atan_deg;
	logic signed [RW:0] mul_a;
	logic signed [COEF_W-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic [MPW-1:0] mean_prod;

	assign up_idx = (cnt_q == IW'(SENSOR_COUNT - 1)) ? '0 : cnt_q + 1'b1;
	assign dn_idx = (cnt_q == '0) ? IW'(SENSOR_COUNT - 1) : cnt_q - 1'b1;
	assign last = (cnt_q == IW'(SENSOR_COUNT - 1));
	assign reading = (int'(in_ch.raw_sample) > SAMPLE_FULL_SCALE) ? '0 :
		RW'(SAMPLE_FULL_SCALE - int'(in_ch.raw_sample));
	assign failed = (rdata == RW'(SAMPLE_FULL_SCALE)) || (rdata == RW'(SAMPLE_FULL_SCALE - 1));
	assign nb_mean = RW'(((RW+1)'(a_q) + (RW+1)'(rdata)) >> 1);
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IN);
	assign accept = in_ch.valid && in_ch.ready;
	assign atan_start = (state_q == S_START);

	assign mul_a = (state_q == S_SM_C) ? $signed({1'b0, rdata}) : $signed({1'b0, rd_q});
	assign mul_b = (state_q == S_SM_C) ? cos_tab[cnt_q] : sin_tab[cnt_q];
	assign mul_p = PW'(mul_a) * PW'(mul_b);
	assign mean_prod = MPW'(msum_q) * MPW'(DIV_M);

	always_comb begin
		we = 1'b0;
		waddr = cnt_q;
		wdata = nb_mean;
		case (state_q)
			S_IN: begin
				we = accept;
				waddr = idx_q;
				wdata = reading;
			end
			S_NB_B: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_RP_CHK, S_PT_RD: raddr = up_idx;
			S_NB_A: raddr = dn_idx;
			default: raddr = cnt_q;
		endcase
	end

	irbe_ram #(.WIDTH(RW), .DEPTH(SENSOR_COUNT)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	irbe_atan #(.XW(XW)) u_atan (
		.clk(clk), .arst_n(arst_n), .start(atan_start), .bx(sx_q), .by(sy_q),
		.done(atan_done), .deg(atan_deg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patched_q <= PATCH_W'(PATCH_RESET);
		end else if (cfg_we) begin
			patched_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_NB_A: a_q <= rdata;
			S_SM_C: begin
				rd_q <= rdata;
				prod_q <= mul_p;
				msum_q <= msum_q + SW'(rdata);
			end
			S_SM_S: begin
				sx_q <= sx_q + XW'(prod_q);
				prod_q <= mul_p;
			end
			S_SM_A: sy_q <= sy_q + XW'(prod_q);
			S_PT: begin
				sx_q <= '0;
				sy_q <= '0;
				msum_q <= '0;
			end
			default: a_q <= a_q;
		endcase
		if (state_q == S_DONE && out_free) begin
			bearing_q <= atan_deg;
			mean_q <= MEAN_W'(mean_prod >> DIV_K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			idx_q <= '0;
			cnt_q <= '0;
			patch_phase_q <= 1'b0;
			bdone_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == S_START) bdone_q <= 1'b0;
			else if (atan_done) bdone_q <= 1'b1;
			case (state_q)
				S_IN: begin
					if (accept) begin
						if (idx_q == IW'(SENSOR_COUNT - 1)) begin
							idx_q <= '0;
							cnt_q <= '0;
							patch_phase_q <= 1'b0;
							state_q <= S_RP_RD;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_RP_RD: state_q <= S_RP_CHK;
				S_RP_CHK: begin
					if (failed) state_q <= S_NB_A;
					else if (last) state_q <= S_PT;
					else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_RP_RD;
					end
				end
				S_NB_A: state_q <= S_NB_B;
				S_NB_B: begin
					if (patch_phase_q) begin
						cnt_q <= '0;
						state_q <= S_SM_RD;
					end else if (last) begin
						state_q <= S_PT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_RP_RD;
					end
				end
				S_PT: begin
					if (int'(patched_q) < SENSOR_COUNT) begin
						cnt_q <= IW'(patched_q);
						patch_phase_q <= 1'b1;
						state_q <= S_PT_RD;
					end else begin
						cnt_q <= '0;
						state_q <= S_SM_RD;
					end
				end
				S_PT_RD: state_q <= S_NB_A;
				S_SM_RD: state_q <= S_SM_C;
				S_SM_C: state_q <= S_SM_S;
				S_SM_S: state_q <= S_SM_A;
				S_SM_A: begin
					if (last) state_q <= S_START;
					else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_SM_RD;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (bdone_q) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IN;
				end
				default: state_q <= S_IN;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.bearing_deg = bearing_q;
	assign out_ch.mean_level = mean_q;

`ifndef NO_ASSERTIONS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IW'(SENSOR_COUNT)) else $error("sample index out of range");
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> waddr < IW'(SENSOR_COUNT)) else $error("store write out of range");
	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IN))
		else $error("finished result not issued");
	a_wait_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && bdone_q) |=> state_q == S_DONE)
		else $error("frame pass stuck waiting");
`endif
endmodule
`default_nettype wire
